// ----- rtl/core/pixel_undistort_normalize_assert.svh -----
// Assertion macros shared by the pixel_undistort_normalize RTL.
`ifndef PIXEL_UNDISTORT_NORMALIZE_ASSERT_SVH
`define PIXEL_UNDISTORT_NORMALIZE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PUN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PUN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pun_pkg.sv -----
package pun_pkg;

    localparam int QF = 28;
    localparam int ITER_STAGES = 7;

    localparam logic [2:0] REG_INV_FOCAL_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_X      = 3'd1;
    localparam logic [2:0] REG_INV_FOCAL_Y   = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1     = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2     = 3'd5;
    localparam logic [2:0] REG_TANGENTIAL_P1 = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL_P2 = 3'd7;

    typedef logic signed [41:0] inter_t;

    localparam inter_t LIM_P = 42'sh0FF_FFFF_FFFF;
    localparam inter_t LIM_N = -42'sh0FF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] pixel_u;
        logic [15:0] pixel_v;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
    } out_item_t;

    // distorted point and current estimate
    typedef struct packed {
        logic signed [31:0] xd;
        logic signed [31:0] yd;
        logic signed [31:0] xu;
        logic signed [31:0] yu;
    } pt_t;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } coef_t;

    function automatic inter_t clamp_lim(input logic signed [43:0] v);
        inter_t r;
        if (v > 44'(LIM_P)) begin
            r = LIM_P;
        end else if (v < 44'(LIM_N)) begin
            r = LIM_N;
        end else begin
            r = v[41:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q.28 product, truncated toward zero; b must lie within +/-LIM_P.
    function automatic inter_t qmul(input logic signed [31:0] a, input inter_t b);
        logic [31:0] ma;
        logic [41:0] mb;
        logic [71:0] prod;
        logic [43:0] sh;
        logic [39:0] m;
        logic        neg;
        inter_t      pos;
        ma   = a[31] ? 32'(-a) : 32'(a);
        mb   = b[41] ? 42'(-b) : 42'(b);
        prod = 72'(ma) * 72'(mb[39:0]);
        sh   = prod[71:QF];
        m    = (sh > 44'(LIM_P)) ? LIM_P[39:0] : sh[39:0];
        neg  = a[31] ^ b[41];
        pos  = $signed({2'b00, m});
        return neg ? -pos : pos;
    endfunction

    // square of a nonnegative Q.28 value with saturation
    function automatic inter_t qsq(input logic [35:0] r);
        logic [67:0] p;
        inter_t      res;
        p = 68'(r[33:0]) * 68'(r[33:0]);
        if (r[35:34] != 2'b00) begin
            res = LIM_P;
        end else begin
            res = $signed({2'b00, p[67:QF]});
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/pun_norm.sv -----
module pun_norm import pun_pkg::*; #(
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  in_item_t           in_item,
    input  logic        [31:0] inv_x,
    input  logic signed [31:0] off_x,
    input  logic        [31:0] inv_y,
    input  logic signed [31:0] off_y,
    output logic               out_valid,
    output pt_t                out_pt
);

    localparam int SHIFT = PIXEL_FRAC_BITS + 4;

    logic [1:0]  valid_reg;
    logic [47:0] prod_x_reg, prod_x_next;
    logic [47:0] prod_y_reg, prod_y_next;
    pt_t         pt_reg, pt_next;

    logic signed [49:0] sum_x, sum_y;

    assign prod_x_next = 48'(in_item.pixel_u) * 48'(inv_x);
    assign prod_y_next = 48'(in_item.pixel_v) * 48'(inv_y);

    always_comb begin
        sum_x      = $signed({2'b00, prod_x_reg >> SHIFT}) + 50'(off_x);
        sum_y      = $signed({2'b00, prod_y_reg >> SHIFT}) + 50'(off_y);
        pt_next.xd = sat32(sum_x);
        pt_next.yd = sat32(sum_y);
        pt_next.xu = pt_next.xd;
        pt_next.yu = pt_next.yd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            pt_reg     <= pt_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_pt    = pt_reg;

endmodule

// ----- rtl/core/pun_iter.sv -----
`include "pixel_undistort_normalize_assert.svh"

// One undistortion step: x_u <= x_d - D(x_u), seven register stages.
module pun_iter import pun_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  coef_t coef,
    input  logic  in_valid,
    input  pt_t   in_pt,
    output logic  out_valid,
    output pt_t   out_pt
);

    logic [ITER_STAGES-1:0] valid_reg;
    pt_t                    pt_reg [ITER_STAGES-1];
    pt_t                    out_pt_reg, out_pt_next;

    // stage 1
    inter_t x2_reg, y2_reg, xy_reg;
    // stage 2
    logic [35:0] rho2_reg, rho2_next;
    inter_t      tx_reg, ty_reg, p1xy2_reg, p2xy2_reg;
    // stage 3
    inter_t k1r_reg, rr_reg, p2tx_reg, p1ty_reg, p1xy2_s3_reg, p2xy2_s3_reg;
    // stage 4
    inter_t k1r_s4_reg, k2rr_reg, tanx_reg, tany_reg;
    // stage 5
    inter_t rad_reg, tanx_s5_reg, tany_s5_reg;
    // stage 6
    inter_t xrad_reg, yrad_reg, tanx_s6_reg, tany_s6_reg;

    inter_t             dx, dy;
    logic signed [49:0] diff_x, diff_y;

    assign rho2_next = 36'(x2_reg + y2_reg);

    always_comb begin
        dx     = clamp_lim(44'(xrad_reg) + 44'(tanx_s6_reg));
        dy     = clamp_lim(44'(yrad_reg) + 44'(tany_s6_reg));
        diff_x = 50'(pt_reg[5].xd) - 50'(dx);
        diff_y = 50'(pt_reg[5].yd) - 50'(dy);
        out_pt_next    = pt_reg[5];
        out_pt_next.xu = sat32(diff_x);
        out_pt_next.yu = sat32(diff_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ITER_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_reg[0] <= in_pt;
            for (int i = 1; i < ITER_STAGES - 1; i++) begin
                pt_reg[i] <= pt_reg[i-1];
            end

            x2_reg <= qmul(in_pt.xu, 42'(in_pt.xu));
            y2_reg <= qmul(in_pt.yu, 42'(in_pt.yu));
            xy_reg <= qmul(in_pt.xu, 42'(in_pt.yu));

            rho2_reg  <= rho2_next;
            tx_reg    <= x2_reg + x2_reg + x2_reg + y2_reg;
            ty_reg    <= y2_reg + y2_reg + y2_reg + x2_reg;
            p1xy2_reg <= qmul(coef.p1, xy_reg) <<< 1;
            p2xy2_reg <= qmul(coef.p2, xy_reg) <<< 1;

            k1r_reg      <= qmul(coef.k1, $signed({6'b0, rho2_reg}));
            rr_reg       <= qsq(rho2_reg);
            p2tx_reg     <= qmul(coef.p2, tx_reg);
            p1ty_reg     <= qmul(coef.p1, ty_reg);
            p1xy2_s3_reg <= p1xy2_reg;
            p2xy2_s3_reg <= p2xy2_reg;

            k1r_s4_reg <= k1r_reg;
            k2rr_reg   <= qmul(coef.k2, rr_reg);
            tanx_reg   <= p1xy2_s3_reg + p2tx_reg;
            tany_reg   <= p2xy2_s3_reg + p1ty_reg;

            rad_reg     <= clamp_lim(44'(k1r_s4_reg) + 44'(k2rr_reg));
            tanx_s5_reg <= tanx_reg;
            tany_s5_reg <= tany_reg;

            xrad_reg    <= qmul(pt_reg[4].xu, rad_reg);
            yrad_reg    <= qmul(pt_reg[4].yu, rad_reg);
            tanx_s6_reg <= tanx_s5_reg;
            tany_s6_reg <= tany_s5_reg;

            out_pt_reg <= out_pt_next;
        end
    end

    assign out_valid = valid_reg[ITER_STAGES-1];
    assign out_pt    = out_pt_reg;

    `PUN_ASSERT_NEXT(a_valid_shift, aclk, aresetn, en,
        valid_reg[ITER_STAGES-1:1] == $past(valid_reg[ITER_STAGES-2:0]),
        "iteration valid bits did not advance")
    `PUN_ASSERT_NEXT(a_valid_hold, aclk, aresetn, !en, $stable(valid_reg),
        "iteration valid bits moved during stall")

endmodule

// ----- rtl/core/pun_out_skid.sv -----
`include "pixel_undistort_normalize_assert.svh"

// Output register plus one skid entry; pipeline advances while skid is empty.
module pun_out_skid import pun_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    output logic      en,
    input  logic      p_valid,
    input  out_item_t p_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_item_reg;
    out_item_t skid_item_reg;
    logic      out_free;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (out_free) begin
                out_valid_reg <= p_valid;
            end else if (p_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (out_free) begin
                out_item_reg <= p_item;
            end else if (p_valid) begin
                skid_item_reg <= p_item;
            end
        end else if (m_ready) begin
            out_item_reg <= skid_item_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    `PUN_ASSERT_NOW(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry held with empty output register")
    `PUN_ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && m_ready,
        !skid_valid_reg && out_valid_reg, "skid entry not moved to output")

endmodule

// ----- rtl/core/pixel_undistort_normalize.sv -----
// Maps a pixel coordinate pair (unsigned, PIXEL_FRAC_BITS fraction bits) to
// undistorted normalized coordinates in signed Q4.28, removing radial (k1, k2)
// and tangential (p1, p2) distortion by ITERATIONS fixed-point steps; a zero
// radial_k1 returns the plain normalized point. Fully pipelined: one item per
// cycle while s_ready is high (two normalization stages, seven stages per
// iteration set by the dependent multiply chain, one output register). The
// output has a register plus one skid entry; s_ready is low while an item
// waits in the skid entry, so after the output stalls input is still taken
// until a valid item reaches the end of the pipeline, and s_ready returns in
// the cycle after that entry drains. Configuration registers are written
// through cfg_we/cfg_index/cfg_wdata and must stay unchanged while items are
// in flight.
module pixel_undistort_normalize import pun_pkg::*; #(
    parameter int ITERATIONS      = 8,
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] inv_x_reg, off_x_reg, inv_y_reg, off_y_reg;
    logic [31:0] k1_reg, k2_reg, p1_reg, p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_x_reg <= '0;
            off_x_reg <= '0;
            inv_y_reg <= '0;
            off_y_reg <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_INV_FOCAL_X:   inv_x_reg <= cfg_wdata;
                REG_OFFSET_X:      off_x_reg <= cfg_wdata;
                REG_INV_FOCAL_Y:   inv_y_reg <= cfg_wdata;
                REG_OFFSET_Y:      off_y_reg <= cfg_wdata;
                REG_RADIAL_K1:     k1_reg    <= cfg_wdata;
                REG_RADIAL_K2:     k2_reg    <= cfg_wdata;
                REG_TANGENTIAL_P1: p1_reg    <= cfg_wdata;
                REG_TANGENTIAL_P2: p2_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic      en;
    coef_t     coef;
    logic      chain_valid [ITERATIONS+1];
    pt_t       chain_pt    [ITERATIONS+1];
    logic      bypass;
    out_item_t p_item;

    assign s_ready = en;
    assign coef    = '{k1: $signed(k1_reg), k2: $signed(k2_reg),
                       p1: $signed(p1_reg), p2: $signed(p2_reg)};

    pun_norm #(
        .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .inv_x     (inv_x_reg),
        .off_x     ($signed(off_x_reg)),
        .inv_y     (inv_y_reg),
        .off_y     ($signed(off_y_reg)),
        .out_valid (chain_valid[0]),
        .out_pt    (chain_pt[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        pun_iter u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .coef      (coef),
            .in_valid  (chain_valid[g]),
            .in_pt     (chain_pt[g]),
            .out_valid (chain_valid[g+1]),
            .out_pt    (chain_pt[g+1])
        );
    end

    assign bypass        = (k1_reg == 32'd0);
    assign p_item.norm_x = bypass ? chain_pt[ITERATIONS].xd : chain_pt[ITERATIONS].xu;
    assign p_item.norm_y = bypass ? chain_pt[ITERATIONS].yd : chain_pt[ITERATIONS].yu;

    pun_out_skid u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .p_valid (chain_valid[ITERATIONS]),
        .p_item  (p_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import pun_pkg::*;

    localparam int FIXPT_STEPS    = 8;
    localparam int PIPE_DEPTH     = 2 + 7 * FIXPT_STEPS + 1;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 112;
    localparam int CHOKE_CYCLES   = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int NUM_PROBES     = 20;
    localparam longint ILIM       = 64'sd1099511627775;

    typedef enum logic [3:0] {
        CAL_RESET,
        CAL_SAT_HI,
        CAL_SAT_LO,
        CAL_LENS,
        CAL_EXTREME,
        CAL_STRONG,
        CAL_RAND_LENS,
        CAL_RAND_RAW,
        CAL_RAND_BYPASS
    } cal_kind_t;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        cal_kind_t   cal;
        logic [15:0] u;
        logic [15:0] v;
        logic        typed;
        logic [31:0] ex;
        logic [31:0] ey;
    } probe_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_item;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_wdata = 32'h0;

    // typed expectation travels alongside the item
    logic        row_typed = 1'b0;
    logic [31:0] row_x     = 32'h0;
    logic [31:0] row_y     = 32'h0;

    logic [31:0] lens_cal [8];
    out_item_t   undist_q [$];

    int          gap_pct      = 0;
    int          stall_pct    = 0;
    logic        choke_req    = 1'b0;
    bit          choke_done   = 1'b0;
    int          choke_left   = 0;
    int          err_count    = 0;
    int          pixels_sent  = 0;
    int          results_seen = 0;
    int          cal_loads    = 0;
    int          cycle_count  = 0;

    probe_row_t probe_table [NUM_PROBES] = '{
        '{CAL_RESET,   16'h0000, 16'h0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{CAL_RESET,   16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{CAL_RESET,   16'hAAAA, 16'h5555, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{CAL_SAT_HI,  16'hFFFF, 16'hFFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{CAL_SAT_HI,  16'h0000, 16'h0000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{CAL_SAT_LO,  16'hFFFF, 16'h0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
        '{CAL_SAT_LO,  16'h1234, 16'h8765, 1'b1, 32'h8000_0000, 32'h8000_0000},
        '{CAL_LENS,    16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{CAL_LENS,    16'hFFFF, 16'hFFFF, 1'b0, 32'h0, 32'h0},
        '{CAL_LENS,    16'h2800, 16'h1680, 1'b0, 32'h0, 32'h0},
        '{CAL_LENS,    16'h0001, 16'hFFFE, 1'b0, 32'h0, 32'h0},
        '{CAL_LENS,    16'h4FFF, 16'h2CFF, 1'b0, 32'h0, 32'h0},
        '{CAL_LENS,    16'h8000, 16'h7FFF, 1'b0, 32'h0, 32'h0},
        '{CAL_EXTREME, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{CAL_EXTREME, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0, 32'h0},
        '{CAL_EXTREME, 16'h8000, 16'h0001, 1'b0, 32'h0, 32'h0},
        '{CAL_EXTREME, 16'h00FF, 16'hFF00, 1'b0, 32'h0, 32'h0},
        '{CAL_STRONG,  16'h0000, 16'hFFFF, 1'b0, 32'h0, 32'h0},
        '{CAL_STRONG,  16'hFFFF, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{CAL_STRONG,  16'h7FFF, 16'h8000, 1'b0, 32'h0, 32'h0}
    };

    pixel_undistort_normalize uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic longint clip40(longint v);
        if (v > ILIM) begin
            return ILIM;
        end
        if (v < -ILIM) begin
            return -ILIM;
        end
        return v;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q.28 product: operands clipped, truncated toward zero, result clipped
    function automatic longint q28_mul(longint a, longint b);
        logic [81:0] mag;
        longint      ca;
        longint      cb;
        bit          neg;
        ca  = clip40(a);
        cb  = clip40(b);
        neg = (ca < 0) != (cb < 0);
        if (ca < 0) begin
            ca = -ca;
        end
        if (cb < 0) begin
            cb = -cb;
        end
        mag = ({18'd0, ca} * {18'd0, cb}) >> 28;
        if (mag > 82'(ILIM)) begin
            mag = 82'(ILIM);
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint norm_axis(logic [15:0] pix, logic [31:0] inv, logic [31:0] off);
        logic [47:0] prod;
        prod = pix * inv;
        return sat_word(longint'({16'd0, prod >> 8}) + longint'($signed(off)));
    endfunction

    function automatic void lens_distort(longint x, longint y, output longint dx,
                                         output longint dy);
        longint k1;
        longint k2;
        longint p1;
        longint p2;
        longint x2;
        longint y2;
        longint xy;
        longint rho2;
        longint rad;
        longint tx;
        longint ty;
        k1   = longint'($signed(lens_cal[REG_RADIAL_K1]));
        k2   = longint'($signed(lens_cal[REG_RADIAL_K2]));
        p1   = longint'($signed(lens_cal[REG_TANGENTIAL_P1]));
        p2   = longint'($signed(lens_cal[REG_TANGENTIAL_P2]));
        x2   = q28_mul(x, x);
        y2   = q28_mul(y, y);
        xy   = q28_mul(x, y);
        rho2 = clip40(x2 + y2);
        rad  = clip40(q28_mul(k1, rho2) + q28_mul(k2, q28_mul(rho2, rho2)));
        tx   = clip40(rho2 + 2 * x2);
        ty   = clip40(rho2 + 2 * y2);
        dx   = clip40(q28_mul(x, rad) + 2 * q28_mul(p1, xy) + q28_mul(p2, tx));
        dy   = clip40(q28_mul(y, rad) + 2 * q28_mul(p2, xy) + q28_mul(p1, ty));
    endfunction

    function automatic out_item_t undistort_pixel(in_item_t px);
        out_item_t res;
        longint    xd;
        longint    yd;
        longint    xu;
        longint    yu;
        longint    dx;
        longint    dy;
        xd = norm_axis(px.pixel_u, lens_cal[REG_INV_FOCAL_X], lens_cal[REG_OFFSET_X]);
        yd = norm_axis(px.pixel_v, lens_cal[REG_INV_FOCAL_Y], lens_cal[REG_OFFSET_Y]);
        xu = xd;
        yu = yd;
        if (lens_cal[REG_RADIAL_K1] != 32'h0) begin
            for (int i = 0; i < FIXPT_STEPS; i++) begin
                lens_distort(xu, yu, dx, dy);
                xu = sat_word(xd - dx);
                yu = sat_word(yd - dy);
            end
        end
        res.norm_x = xu[31:0];
        res.norm_y = yu[31:0];
        return res;
    endfunction

    function automatic logic [31:0] signed_rand(int unsigned mag);
        logic [31:0] m;
        m = $urandom_range(1, mag);
        return $urandom_range(0, 1) ? m : 32'd0 - m;
    endfunction

    task automatic note_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct = 0;
                stall_pct <= 0;
            end
            IDLE_SRC: begin
                gap_pct = 74;
                stall_pct <= 0;
            end
            IDLE_SNK: begin
                gap_pct = 0;
                stall_pct <= 74;
            end
            default: begin
                gap_pct = 23;
                stall_pct <= 23;
            end
        endcase
    endtask

    task automatic program_lens(cal_kind_t kind);
        logic [31:0] v [8];
        for (int i = 0; i < 8; i++) begin
            v[i] = 32'h0;
        end
        case (kind)
            CAL_SAT_HI: begin
                v[REG_INV_FOCAL_X] = 32'hFFFF_FFFF;
                v[REG_OFFSET_X]    = 32'h7FFF_FFFF;
                v[REG_INV_FOCAL_Y] = 32'hFFFF_FFFF;
                v[REG_OFFSET_Y]    = 32'h7FFF_FFFF;
            end
            CAL_SAT_LO: begin
                // k1 stays zero, so the other coefficients must not matter
                v[REG_OFFSET_X]      = 32'h8000_0000;
                v[REG_OFFSET_Y]      = 32'h8000_0000;
                v[REG_RADIAL_K2]     = 32'h7FFF_FFFF;
                v[REG_TANGENTIAL_P1] = 32'h8000_0000;
                v[REG_TANGENTIAL_P2] = 32'h1234_5678;
            end
            CAL_LENS: begin
                // fx = fy = 500, center (640, 360), mild barrel
                v[REG_INV_FOCAL_X]   = 32'd8589935;
                v[REG_OFFSET_X]      = -32'sd343597384;
                v[REG_INV_FOCAL_Y]   = 32'd8589935;
                v[REG_OFFSET_Y]      = -32'sd193273528;
                v[REG_RADIAL_K1]     = -32'sd80530637;
                v[REG_RADIAL_K2]     = 32'sd26843546;
                v[REG_TANGENTIAL_P1] = 32'sd268435;
                v[REG_TANGENTIAL_P2] = -32'sd134218;
            end
            CAL_EXTREME: begin
                v[REG_INV_FOCAL_X]   = 32'hFFFF_FFFF;
                v[REG_OFFSET_X]      = 32'h8000_0000;
                v[REG_INV_FOCAL_Y]   = 32'h0000_0001;
                v[REG_OFFSET_Y]      = 32'h7FFF_FFFF;
                v[REG_RADIAL_K1]     = 32'h8000_0000;
                v[REG_RADIAL_K2]     = 32'h7FFF_FFFF;
                v[REG_TANGENTIAL_P1] = 32'h7FFF_FFFF;
                v[REG_TANGENTIAL_P2] = 32'h8000_0000;
            end
            CAL_STRONG: begin
                v[REG_INV_FOCAL_X]   = 32'h0100_0000;
                v[REG_INV_FOCAL_Y]   = 32'h0100_0000;
                v[REG_RADIAL_K1]     = 32'h7FFF_FFFF;
                v[REG_RADIAL_K2]     = 32'h8000_0000;
                v[REG_TANGENTIAL_P1] = 32'h8000_0000;
                v[REG_TANGENTIAL_P2] = 32'h7FFF_FFFF;
            end
            CAL_RAND_LENS: begin
                v[REG_INV_FOCAL_X]   = $urandom_range(2147483, 21474836);
                v[REG_OFFSET_X]      = 32'd0 - $urandom_range(0, 536870912);
                v[REG_INV_FOCAL_Y]   = $urandom_range(2147483, 21474836);
                v[REG_OFFSET_Y]      = 32'd0 - $urandom_range(0, 536870912);
                v[REG_RADIAL_K1]     = signed_rand(134217728);
                v[REG_RADIAL_K2]     = signed_rand(80530637);
                v[REG_TANGENTIAL_P1] = signed_rand(2684354);
                v[REG_TANGENTIAL_P2] = signed_rand(2684354);
            end
            CAL_RAND_RAW: begin
                for (int i = 0; i < 8; i++) begin
                    v[i] = $urandom;
                end
            end
            CAL_RAND_BYPASS: begin
                for (int i = 0; i < 8; i++) begin
                    v[i] = $urandom;
                end
                v[REG_RADIAL_K1] = 32'h0;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_we      <= 1'b1;
            cfg_index   <= 3'(i);
            cfg_wdata   <= v[i];
            lens_cal[i] = v[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        cal_loads++;
    endtask

    task automatic offer_pixel(logic [15:0] u, logic [15:0] v, logic typed,
                               logic [31:0] ex, logic [31:0] ey);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_item    <= '{pixel_u: u, pixel_v: v};
        row_typed <= typed;
        row_x     <= ex;
        row_y     <= ey;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic finish_burst();
        s_valid <= 1'b0;
        // let the scoreboard log the last accepted item first
        @(posedge aclk);
        while (undist_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (choke_req && !choke_done) begin
            choke_left = CHOKE_CYCLES;
            choke_done = 1'b1;
        end
        if (choke_left > 0) begin
            choke_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (row_typed) begin
                    want = '{norm_x: row_x, norm_y: row_y};
                end else begin
                    want = undistort_pixel(s_item);
                end
                undist_q.push_back(want);
                pixels_sent++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (undist_q.size() == 0) begin
                    note_error($sformatf("unexpected item %h", m_item));
                end else begin
                    want = undist_q.pop_front();
                    if (m_item.norm_x !== want.norm_x) begin
                        note_error($sformatf("item %0d norm_x %h, want %h",
                                             results_seen, m_item.norm_x, want.norm_x));
                    end
                    if (m_item.norm_y !== want.norm_y) begin
                        note_error($sformatf("item %0d norm_y %h, want %h",
                                             results_seen, m_item.norm_y, want.norm_y));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending", cycle_count,
                     undist_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        cal_kind_t   cur_cal;
        logic [15:0] u;
        logic [15:0] v;
        cur_cal = CAL_RESET;
        for (int i = 0; i < 8; i++) begin
            lens_cal[i] = 32'h0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(IDLE_BOTH);
        foreach (probe_table[i]) begin
            if (probe_table[i].cal != cur_cal) begin
                finish_burst();
                program_lens(probe_table[i].cal);
                cur_cal = probe_table[i].cal;
            end
            offer_pixel(probe_table[i].u, probe_table[i].v, probe_table[i].typed,
                        probe_table[i].ex, probe_table[i].ey);
        end
        finish_burst();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idle(idle_mode_t'(p % 4));
            program_lens(p % 3 == 0 ? CAL_RAND_LENS :
                         p % 3 == 1 ? CAL_RAND_RAW : CAL_RAND_BYPASS);
            // long output hold-off while input keeps coming
            if (p == 0) begin
                choke_req <= 1'b1;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                u = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 20479))
                                                : 16'($urandom);
                v = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 11519))
                                                : 16'($urandom);
                offer_pixel(u, v, 1'b0, 32'h0, 32'h0);
            end
            finish_burst();
        end

        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (undist_q.size() != 0) begin
            note_error($sformatf("%0d items never came out", undist_q.size()));
        end
        $display("%0d pixels over %0d calibration sets, %0d results compared",
                 pixels_sent, cal_loads, results_seen);
        $display("bypass, saturation extremes, lens and raw coefficients, output hold-off");
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
